// ===== rtl/filtered_temperature_query_responder_assert.svh =====
// Assertion macros shared by the responder RTL.
// Depends on a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef FILTERED_TEMPERATURE_QUERY_RESPONDER_ASSERT_SVH
`define FILTERED_TEMPERATURE_QUERY_RESPONDER_ASSERT_SVH
// Same-cycle implication.
`define FTQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ftq assertion failed");
// Next-cycle implication.
`define FTQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ftq assertion failed");
`endif

// ===== rtl/ftq_pkg.sv =====
// Shared types and constants of the filtered temperature query responder.
// No dependencies.
package ftq_pkg;
    localparam int ACC_W  = 57;
    localparam int MPL_W  = 30;
    localparam int LEN_W  = 5;
    localparam logic [16:0] Q16_ONE   = 17'd65536;
    localparam logic [15:0] ERROR_WORD = 16'hFFFF;
    localparam logic [15:0] TEMP_MAX   = 16'd65534;
    localparam logic [7:0]  CH_R  = 8'h52;
    localparam logic [7:0]  CH_T  = 8'h54;
    localparam logic [7:0]  CH_CR = 8'h0D;
    localparam logic [7:0]  CH_LF = 8'h0A;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_BYTE   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_MPC    = 2'd0,
        REG_WEIGHT = 2'd1,
        REG_SLOPE  = 2'd2,
        REG_OFFSET = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE, S_MV, S_F1, S_F2, S_TSTART, S_T
    } t_state;

    typedef struct packed {
        logic emit;
        logic err;
    } t_cmd_res;

    typedef struct packed {
        logic                     start;
        logic signed [ACC_W-1:0]  init;
        logic signed [ACC_W-1:0]  mcand;
        logic [MPL_W-1:0]         mplier;
        logic [LEN_W-1:0]         len;
    } t_mul_req;
endpackage

// ===== rtl/ftq_smul.sv =====
// Bit-serial shift-add multiply-accumulate unit: one multiplier bit per cycle.
// Depends on ftq_pkg and the assertion macro header.
`include "filtered_temperature_query_responder_assert.svh"
module ftq_smul import ftq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mul_req                i_req,
    output logic                    o_done,
    output logic signed [ACC_W-1:0] o_acc
);
    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [LEN_W-1:0]        r_cnt, n_cnt;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [ACC_W-1:0] r_mcand, n_mcand;
    logic [MPL_W-1:0]        r_mplier, n_mplier;

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        if (i_req.start) begin
            n_busy   = 1'b1;
            n_cnt    = i_req.len;
            n_acc    = i_req.init;
            n_mcand  = i_req.mcand;
            n_mplier = i_req.mplier;
        end else if (r_busy) begin
            // add the shifted multiplicand for a set bit, then advance one bit
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = r_mcand <<< 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt - LEN_W'(1);
            if (r_cnt == LEN_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

    `FTQ_ASSERT_NEXT(a_start_busy, i_req.start && i_req.len != '0, r_busy)
    `FTQ_ASSERT_NOW(a_done_idle, r_done, !r_busy)
    `FTQ_ASSERT_NOW(a_busy_count, r_busy, r_cnt != '0)
endmodule

// ===== rtl/ftq_cmd.sv =====
// Serial command parser: tracks the four-byte query and flags replies.
// Depends on ftq_pkg.
module ftq_cmd import ftq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_strobe,
    input  logic [7:0] i_byte,
    output t_cmd_res   o_res
);
    logic [1:0] r_pos, n_pos;
    logic       r_match, n_match;
    logic [7:0] expect_byte;
    logic       hit;

    always_comb begin
        case (r_pos)
            2'd0:    expect_byte = CH_R;
            2'd1:    expect_byte = CH_T;
            2'd2:    expect_byte = CH_CR;
            default: expect_byte = CH_LF;
        endcase
        hit       = (i_byte == expect_byte);
        n_pos     = r_pos;
        n_match   = r_match;
        o_res     = '0;
        if (i_strobe) begin
            if (r_pos == 2'd0 && !hit) begin
                // reject at once, stay at the start
                n_match   = 1'b1;
                o_res.emit = 1'b1;
                o_res.err  = 1'b1;
            end else if (r_pos == 2'd3) begin
                o_res.emit = 1'b1;
                o_res.err  = !(r_match && hit);
                n_pos      = 2'd0;
                n_match    = 1'b1;
            end else begin
                n_match = r_match && hit;
                n_pos   = r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 2'd0;
            r_match <= 1'b1;
        end else begin
            r_pos   <= n_pos;
            r_match <= n_match;
        end
    end
endmodule

// ===== rtl/filtered_temperature_query_responder.sv =====
// Filtered temperature query responder: usage summary below.
// Top level; depends on ftq_pkg, ftq_smul, ftq_cmd and the assertion header.
//
// Input channel (i_in_valid/o_in_ready) carries items: mode 0 stores an ADC
// count, mode 1 is an update tick, mode 2 is one received command byte,
// mode 3 is dropped. Output channel (o_out_valid/i_out_ready) carries one
// reply per finished or rejected command. Config channel (i_cfg_valid/
// o_cfg_ready) writes one register per item and is always ready; write only
// while idle. Sample, byte and ignored items leave the sequencer idle; a byte
// that ends or rejects a command shows its reply in the register the next cycle.
// A tick runs a bit-serial shift-add unit for the millivolt product, two passes
// for the filter (skipped on the first tick), a launch state and the temperature
// product; input ready returns once the temperature is stored. The multiply
// unit handles one multiplier bit per cycle.
// Reset restores the default register values, clears the filter, the kept
// temperature and the command parser. While the receiver stalls a waiting
// reply holds, and every input item waits until the reply register is empty
// or being drained.
`include "filtered_temperature_query_responder_assert.svh"
module filtered_temperature_query_responder import ftq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [11:0] i_adc_sample,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_reply_word,
    output logic        o_reply_is_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    // configuration registers
    logic [16:0]        r_mpc;
    logic [16:0]        r_weight;
    logic signed [23:0] r_slope;
    logic signed [31:0] r_offset;

    // block state
    logic [11:0] r_count;
    logic [29:0] r_filt, n_filt;
    logic        r_primed, n_primed;
    logic [15:0] r_temp, n_temp;
    t_state      r_state, n_state;

    logic        r_ov;
    logic [15:0] r_word;
    logic        r_err;

    t_mul_req                mul_req;
    logic                    mul_done;
    logic signed [ACC_W-1:0] mul_acc;
    t_cmd_res                cmd_res;

    logic        in_acc;
    logic [16:0] w_sat, w_comp;
    logic [55:0] t_round;
    logic [23:0] t_int;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && (!r_ov || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;

    assign w_sat   = (r_weight > Q16_ONE) ? Q16_ONE : r_weight;
    assign w_comp  = Q16_ONE - w_sat;
    assign t_round = mul_acc[55:0] + 56'h0000_0080_0000_00;
    assign t_int   = t_round[55:32];

    ftq_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_acc   (mul_acc)
    );

    ftq_cmd u_cmd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_strobe (in_acc && (i_mode == MODE_BYTE)),
        .i_byte   (i_rx_byte),
        .o_res    (cmd_res)
    );

    // tick sequencer
    always_comb begin
        n_state  = r_state;
        n_filt   = r_filt;
        n_primed = r_primed;
        n_temp   = r_temp;
        mul_req  = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_mode == MODE_TICK) begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = ACC_W'(r_mpc);
                    mul_req.mplier = MPL_W'(r_count);
                    mul_req.len    = LEN_W'(12);
                    n_state        = S_MV;
                end
            end
            S_MV: begin
                if (mul_done) begin
                    if (!r_primed) begin
                        // first tick loads the filter directly
                        n_filt   = 30'(mul_acc[28:0]);
                        n_primed = 1'b1;
                        n_state  = S_TSTART;
                    end else begin
                        mul_req.start  = 1'b1;
                        mul_req.init   = ACC_W'(32768);
                        mul_req.mcand  = ACC_W'(mul_acc[28:0]);
                        mul_req.mplier = MPL_W'(w_sat);
                        mul_req.len    = LEN_W'(17);
                        n_state        = S_F1;
                    end
                end
            end
            S_F1: begin
                if (mul_done) begin
                    mul_req.start  = 1'b1;
                    mul_req.init   = mul_acc;
                    mul_req.mcand  = ACC_W'(r_filt);
                    mul_req.mplier = MPL_W'(w_comp);
                    mul_req.len    = LEN_W'(17);
                    n_state        = S_F2;
                end
            end
            S_F2: begin
                if (mul_done) begin
                    n_filt  = mul_acc[45:16];
                    n_state = S_TSTART;
                end
            end
            S_TSTART: begin
                mul_req.start  = 1'b1;
                mul_req.init   = ACC_W'({r_offset, 16'h0000}) |
                                 (r_offset[31] ? {{(ACC_W-48){1'b1}}, 48'h0} : '0);
                mul_req.mcand  = ACC_W'(r_slope);
                mul_req.mplier = r_filt;
                mul_req.len    = LEN_W'(30);
                n_state        = S_T;
            end
            S_T: begin
                if (mul_done) begin
                    // clamp negatives, round half away, saturate
                    if (mul_acc[ACC_W-1]) begin
                        n_temp = '0;
                    end else if (t_int > 24'(TEMP_MAX)) begin
                        n_temp = TEMP_MAX;
                    end else begin
                        n_temp = t_int[15:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mpc    <= 17'd52429;
            r_weight <= 17'd6554;
            r_slope  <= -24'sd378264;
            r_offset <= 32'sd1088007041;
            r_count  <= '0;
            r_filt   <= '0;
            r_primed <= 1'b0;
            r_temp   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_filt   <= n_filt;
            r_primed <= n_primed;
            r_temp   <= n_temp;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_MPC:    r_mpc    <= i_cfg_data[16:0];
                    REG_WEIGHT: r_weight <= i_cfg_data[16:0];
                    REG_SLOPE:  r_slope  <= i_cfg_data[23:0];
                    REG_OFFSET: r_offset <= i_cfg_data;
                    default:    r_offset <= r_offset;
                endcase
            end
            if (in_acc && i_mode == MODE_SAMPLE) begin
                r_count <= i_adc_sample;
            end
            // hold a reply until taken, load the next one
            if (cmd_res.emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
        if (cmd_res.emit) begin
            r_word <= cmd_res.err ? ERROR_WORD : r_temp;
            r_err  <= cmd_res.err;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_reply_word     = r_word;
    assign o_reply_is_error = r_err;

    `FTQ_ASSERT_NOW(a_accept_idle, i_in_valid && o_in_ready, r_state == S_IDLE)
    `FTQ_ASSERT_NEXT(a_hold_reply, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_reply_word))
    `FTQ_ASSERT_NOW(a_err_word, o_out_valid && o_reply_is_error, o_reply_word == ERROR_WORD)
endmodule
